// ===== rtl/usbmsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and match functions for the USB mass-storage
// descriptor scanner. No dependencies.
package usbmsc_pkg;

    localparam logic [7:0] TYPE_INTERFACE = 8'h04;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
    localparam logic [7:0] ATTR_BULK      = 8'h02;
    localparam int unsigned DIR_IN_BIT    = 7;
    localparam logic [7:0] CLASS_RESET    = 8'h08;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;

    // Header byte positions.
    localparam logic [15:0] POS_HDR_LEN   = 16'd0;
    localparam logic [15:0] POS_TOTAL_LO  = 16'd2;
    localparam logic [15:0] POS_TOTAL_HI  = 16'd3;
    localparam logic [15:0] POS_CFG_VALUE = 16'd5;

    // Offsets inside a sub-descriptor.
    localparam logic [7:0] OFS_TYPE      = 8'd1;
    localparam logic [7:0] OFS_IFACE_NUM = 8'd2;
    localparam logic [7:0] OFS_EP_ADDR   = 8'd2;
    localparam logic [7:0] OFS_EP_ATTR   = 8'd3;
    localparam logic [7:0] OFS_CLASS     = 8'd5;
    localparam logic [7:0] OFS_SUBCLASS  = 8'd6;
    localparam logic [7:0] OFS_PROTOCOL  = 8'd7;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_IFACE  = 2'd1,
        STATUS_NO_EP     = 2'd2,
        STATUS_ZERO_LEN  = 2'd3
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] interface_number;
        logic [3:0] in_endpoint;
        logic [3:0] out_endpoint;
        logic [7:0] config_id;
    } result_t;

    function automatic logic subclass_ok(input logic [7:0] s);
        return (s == 8'h06) || (s == 8'h01) || (s == 8'h02) ||
               (s == 8'h04) || (s == 8'h05);
    endfunction

    function automatic logic protocol_ok(input logic [7:0] p);
        return (p == 8'h50) || (p == 8'h00) || (p == 8'h01) ||
               (p == 8'h02) || (p == 8'h62);
    endfunction

endpackage

// ===== rtl/usb_msc_descriptor_scanner.sv =====
`timescale 1ns / 1ps
// Top level of the USB mass-storage configuration descriptor scanner.
// Depends on usbmsc_pkg for constants, result type and match functions.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------------
//  input     | in_valid / in_stall     | desc_byte, last_byte
//  result    | out_valid / out_stall   | status, interface_number, in_endpoint,
//            |                         | out_endpoint, config_id
//  config    | cfg_wr_en               | cfg_wr_data (device_class)
//
// One byte is taken per cycle while in_stall is low; the scan state updates in the
// cycle the byte is accepted and a result, given only for the byte marked last, is registered.
// A two-entry output queue (result register plus skid) lets input continue
// while a result waits; in_stall rises only when both entries are full.
// Reset clears the scan state and sets device_class to mass storage (8).
module usb_msc_descriptor_scanner (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] desc_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] interface_number,
    output logic [3:0] in_endpoint,
    output logic [3:0] out_endpoint,
    output logic [7:0] config_id,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic [7:0]  device_class_reg;
    logic [7:0]  header_len_reg, header_len_next;
    logic [15:0] total_len_reg, total_len_next;
    logic [15:0] stream_pos_reg, stream_pos_next;
    logic [7:0]  desc_len_reg, desc_len_next;
    logic [7:0]  desc_offset_reg, desc_offset_next;
    logic [7:0]  desc_type_reg, desc_type_next;
    logic [7:0]  cand_num_reg, cand_num_next;
    logic [7:0]  cand_class_reg, cand_class_next;
    logic [7:0]  cand_sub_reg, cand_sub_next;
    logic [7:0]  cand_proto_reg, cand_proto_next;
    logic [7:0]  ep_address_reg, ep_address_next;
    logic        iface_found_reg, iface_found_next;
    logic [7:0]  iface_num_reg, iface_num_next;
    logic [3:0]  in_ep_reg, in_ep_next;
    logic [3:0]  out_ep_reg, out_ep_next;
    logic [7:0]  cfg_value_reg, cfg_value_next;
    logic        scan_done_reg, scan_done_next;
    logic        zero_err_reg, zero_err_next;

    usbmsc_pkg::result_t res_next, out_data_reg, skid_data_reg;
    logic out_valid_reg, skid_valid_reg;
    logic accept, pop, res_valid;
    logic do_eval;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid_reg && !out_stall;
    assign res_valid = accept && last_byte;

    always_comb
    begin
        header_len_next  = header_len_reg;
        total_len_next   = total_len_reg;
        desc_len_next    = desc_len_reg;
        desc_offset_next = desc_offset_reg;
        desc_type_next   = desc_type_reg;
        cand_num_next    = cand_num_reg;
        cand_class_next  = cand_class_reg;
        cand_sub_next    = cand_sub_reg;
        cand_proto_next  = cand_proto_reg;
        ep_address_next  = ep_address_reg;
        iface_found_next = iface_found_reg;
        iface_num_next   = iface_num_reg;
        in_ep_next       = in_ep_reg;
        out_ep_next      = out_ep_reg;
        cfg_value_next   = cfg_value_reg;
        scan_done_next   = scan_done_reg;
        zero_err_next    = zero_err_reg;
        do_eval          = 1'b0;

        if (!scan_done_reg)
        begin
            if (stream_pos_reg == usbmsc_pkg::POS_HDR_LEN)
                header_len_next = desc_byte;
            else if (stream_pos_reg == usbmsc_pkg::POS_TOTAL_LO)
                total_len_next = {total_len_reg[15:8], desc_byte};
            else if (stream_pos_reg == usbmsc_pkg::POS_TOTAL_HI)
                total_len_next = {desc_byte, total_len_reg[7:0]};
            else if (stream_pos_reg == usbmsc_pkg::POS_CFG_VALUE)
                cfg_value_next = desc_byte;

            // The walk compares against the header length as it stands after
            // this byte, so a zero header length walks from position zero.
            if (stream_pos_reg >= {8'd0, header_len_next})
            begin
                if (desc_len_reg == 8'd0)
                begin
                    // The bound uses the total length captured so far, this byte included.
                    if (stream_pos_reg >= total_len_next)
                        scan_done_next = 1'b1;
                    else if (desc_byte == 8'd0)
                    begin
                        zero_err_next  = 1'b1;
                        scan_done_next = 1'b1;
                    end
                    else
                    begin
                        // A one-byte descriptor has no type, so it never matches.
                        desc_len_next    = (desc_byte == 8'd1) ? 8'd0 : desc_byte;
                        desc_offset_next = usbmsc_pkg::OFS_TYPE;
                        desc_type_next   = 8'd0;
                        cand_num_next    = 8'd0;
                        cand_class_next  = 8'd0;
                        cand_sub_next    = 8'd0;
                        cand_proto_next  = 8'd0;
                        ep_address_next  = 8'd0;
                    end
                end
                else
                begin
                    if (desc_offset_reg == usbmsc_pkg::OFS_TYPE)
                        desc_type_next = desc_byte;
                    else if (desc_type_reg == usbmsc_pkg::TYPE_ENDPOINT)
                    begin
                        if (desc_offset_reg == usbmsc_pkg::OFS_EP_ADDR)
                            ep_address_next = desc_byte;
                        else if (desc_offset_reg == usbmsc_pkg::OFS_EP_ATTR)
                            cand_class_next = desc_byte;
                    end
                    else
                    begin
                        if (desc_offset_reg == usbmsc_pkg::OFS_IFACE_NUM)
                            cand_num_next = desc_byte;
                        else if (desc_offset_reg == usbmsc_pkg::OFS_CLASS)
                            cand_class_next = desc_byte;
                        else if (desc_offset_reg == usbmsc_pkg::OFS_SUBCLASS)
                            cand_sub_next = desc_byte;
                        else if (desc_offset_reg == usbmsc_pkg::OFS_PROTOCOL)
                            cand_proto_next = desc_byte;
                    end

                    if ({1'b0, desc_offset_reg} + 9'd1 >= {1'b0, desc_len_reg})
                    begin
                        do_eval          = 1'b1;
                        desc_len_next    = 8'd0;
                        desc_offset_next = 8'd0;
                    end
                    else
                        desc_offset_next = desc_offset_reg + 8'd1;
                end
            end
        end

        if (do_eval)
        begin
            if (desc_type_next == usbmsc_pkg::TYPE_INTERFACE)
            begin
                if (cand_class_next == device_class_reg &&
                    usbmsc_pkg::subclass_ok(cand_sub_next) &&
                    usbmsc_pkg::protocol_ok(cand_proto_next))
                begin
                    iface_num_next   = cand_num_next;
                    iface_found_next = 1'b1;
                end
            end
            else if (desc_type_next == usbmsc_pkg::TYPE_ENDPOINT && iface_found_reg)
            begin
                if (cand_class_next == usbmsc_pkg::ATTR_BULK)
                begin
                    if (ep_address_next[usbmsc_pkg::DIR_IN_BIT])
                        in_ep_next = ep_address_next[3:0];
                    else
                        out_ep_next = ep_address_next[3:0];
                end
                if (in_ep_next != 4'd0 && out_ep_next != 4'd0)
                    scan_done_next = 1'b1;
            end
        end

        stream_pos_next = (stream_pos_reg != usbmsc_pkg::POS_MAX) ?
                          stream_pos_reg + 16'd1 : stream_pos_reg;

        if (zero_err_next)
            res_next.status = usbmsc_pkg::STATUS_ZERO_LEN;
        else if (!iface_found_next)
            res_next.status = usbmsc_pkg::STATUS_NO_IFACE;
        else if (in_ep_next == 4'd0 || out_ep_next == 4'd0)
            res_next.status = usbmsc_pkg::STATUS_NO_EP;
        else
            res_next.status = usbmsc_pkg::STATUS_OK;
        res_next.interface_number = iface_num_next;
        res_next.in_endpoint      = in_ep_next;
        res_next.out_endpoint     = out_ep_next;
        res_next.config_id        = cfg_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            device_class_reg <= usbmsc_pkg::CLASS_RESET;
        else if (cfg_wr_en)
            device_class_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_len_reg  <= 8'd0;
            total_len_reg   <= 16'd0;
            stream_pos_reg  <= 16'd0;
            desc_len_reg    <= 8'd0;
            desc_offset_reg <= 8'd0;
            desc_type_reg   <= 8'd0;
            cand_num_reg    <= 8'd0;
            cand_class_reg  <= 8'd0;
            cand_sub_reg    <= 8'd0;
            cand_proto_reg  <= 8'd0;
            ep_address_reg  <= 8'd0;
            iface_found_reg <= 1'b0;
            iface_num_reg   <= 8'd0;
            in_ep_reg       <= 4'd0;
            out_ep_reg      <= 4'd0;
            cfg_value_reg   <= 8'd0;
            scan_done_reg   <= 1'b0;
            zero_err_reg    <= 1'b0;
        end
        else if (res_valid)
        begin
            // The last byte of a stream returns the scan to its start.
            header_len_reg  <= 8'd0;
            total_len_reg   <= 16'd0;
            stream_pos_reg  <= 16'd0;
            desc_len_reg    <= 8'd0;
            desc_offset_reg <= 8'd0;
            desc_type_reg   <= 8'd0;
            cand_num_reg    <= 8'd0;
            cand_class_reg  <= 8'd0;
            cand_sub_reg    <= 8'd0;
            cand_proto_reg  <= 8'd0;
            ep_address_reg  <= 8'd0;
            iface_found_reg <= 1'b0;
            iface_num_reg   <= 8'd0;
            in_ep_reg       <= 4'd0;
            out_ep_reg      <= 4'd0;
            cfg_value_reg   <= 8'd0;
            scan_done_reg   <= 1'b0;
            zero_err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            header_len_reg  <= header_len_next;
            total_len_reg   <= total_len_next;
            stream_pos_reg  <= stream_pos_next;
            desc_len_reg    <= desc_len_next;
            desc_offset_reg <= desc_offset_next;
            desc_type_reg   <= desc_type_next;
            cand_num_reg    <= cand_num_next;
            cand_class_reg  <= cand_class_next;
            cand_sub_reg    <= cand_sub_next;
            cand_proto_reg  <= cand_proto_next;
            ep_address_reg  <= ep_address_next;
            iface_found_reg <= iface_found_next;
            iface_num_reg   <= iface_num_next;
            in_ep_reg       <= in_ep_next;
            out_ep_reg      <= out_ep_next;
            cfg_value_reg   <= cfg_value_next;
            scan_done_reg   <= scan_done_next;
            zero_err_reg    <= zero_err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= res_next;
            else
                out_data_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_data_reg.status;
    assign interface_number = out_data_reg.interface_number;
    assign in_endpoint      = out_data_reg.in_endpoint;
    assign out_endpoint     = out_data_reg.out_endpoint;
    assign config_id        = out_data_reg.config_id;

endmodule

// ===== bench/usb_msc_descriptor_scanner_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for usb_msc_descriptor_scanner: feeds descriptor byte streams,
// predicts the one status report of each stream and checks every report field.
// Depends on usbmsc_pkg and the scanner RTL.
module usb_msc_descriptor_scanner_tb;
    import usbmsc_pkg::*;

    localparam int unsigned CLK_HALF        = 6;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned ITEMS_PER_PHASE = 225;
    localparam int unsigned MAX_SHOWN       = 10;

    localparam logic [7:0] TYPE_CONFIG         = 8'h02;

    localparam logic [7:0] SUBCLASS_RBC   = 8'h01;
    localparam logic [7:0] SUBCLASS_ATAPI = 8'h02;
    localparam logic [7:0] SUBCLASS_UFI   = 8'h04;
    localparam logic [7:0] SUBCLASS_SFF   = 8'h05;
    localparam logic [7:0] SUBCLASS_SCSI  = 8'h06;

    localparam logic [7:0] PROTO_CBI_INT = 8'h00;
    localparam logic [7:0] PROTO_CBI     = 8'h01;
    localparam logic [7:0] PROTO_OBSOLETE = 8'h02;
    localparam logic [7:0] PROTO_BOT     = 8'h50;
    localparam logic [7:0] PROTO_UAS     = 8'h62;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } scan_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] desc_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    logic [7:0] interface_number;
    logic [3:0] in_endpoint;
    logic [3:0] out_endpoint;
    logic [7:0] config_id;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;

    usb_msc_descriptor_scanner dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .desc_byte        (desc_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .interface_number (interface_number),
        .in_endpoint      (in_endpoint),
        .out_endpoint     (out_endpoint),
        .config_id        (config_id),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    scan_item_t  scan_items_q[$];
    result_t     expected_reports[$];
    logic [7:0]  stream_buf[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        byte_taken = 1'b0;
    int unsigned fail_count = 0;
    int unsigned bytes_seen = 0;
    int unsigned reports_checked = 0;
    int unsigned streams_sent = 0;
    int unsigned phase_items = 0;

    // Scanner state as the bench sees it.
    logic [7:0]      match_class = CLASS_RESET;
    logic [7:0]      hdr_len;
    logic [15:0]     tot_len;
    logic [15:0]     scan_pos;
    logic [7:0]      dlen;
    logic [7:0]      dofs;
    logic [7:0]      dtype;
    logic [3:0][7:0] cand;
    logic [7:0]      ep_addr;
    logic            iface_hit;
    logic [7:0]      iface_num;
    logic [3:0]      in_num;
    logic [3:0]      out_num;
    logic [7:0]      cfg_val;
    logic            scan_over;
    logic            zero_len_hit;

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    task automatic clear_scan_state();
        hdr_len      = '0;
        tot_len      = '0;
        scan_pos     = '0;
        dlen         = '0;
        dofs         = '0;
        dtype        = '0;
        cand         = '0;
        ep_addr      = '0;
        iface_hit    = 1'b0;
        iface_num    = '0;
        in_num       = '0;
        out_num      = '0;
        cfg_val      = '0;
        scan_over    = 1'b0;
        zero_len_hit = 1'b0;
    endtask

    // Called when a sub-descriptor is complete.
    task automatic judge_descriptor();
        logic sub_hit;
        logic proto_hit;
        sub_hit = cand[2] == SUBCLASS_SCSI || cand[2] == SUBCLASS_RBC ||
                  cand[2] == SUBCLASS_ATAPI || cand[2] == SUBCLASS_UFI ||
                  cand[2] == SUBCLASS_SFF;
        proto_hit = cand[3] == PROTO_BOT || cand[3] == PROTO_CBI_INT ||
                    cand[3] == PROTO_CBI || cand[3] == PROTO_OBSOLETE ||
                    cand[3] == PROTO_UAS;
        if (dtype == TYPE_INTERFACE)
        begin
            if (cand[1] == match_class && sub_hit && proto_hit)
            begin
                iface_num = cand[0];
                iface_hit = 1'b1;
            end
        end
        else if (dtype == TYPE_ENDPOINT && iface_hit)
        begin
            if (cand[1] == ATTR_BULK)
            begin
                if (ep_addr[DIR_IN_BIT])
                    in_num = ep_addr[3:0];
                else
                    out_num = ep_addr[3:0];
            end
            if (in_num != 4'd0 && out_num != 4'd0)
                scan_over = 1'b1;
        end
    endtask

    task automatic predict_scan(input logic [7:0] b, input logic last);
        result_t r;
        if (!scan_over)
        begin
            // Header fields sit at fixed positions, even inside the walk.
            if (scan_pos == POS_HDR_LEN)
                hdr_len = b;
            else if (scan_pos == POS_TOTAL_LO)
                tot_len[7:0] = b;
            else if (scan_pos == POS_TOTAL_HI)
                tot_len[15:8] = b;
            else if (scan_pos == POS_CFG_VALUE)
                cfg_val = b;

            if (scan_pos >= {8'd0, hdr_len})
            begin
                if (dlen == 8'd0)
                begin
                    if (scan_pos >= tot_len)
                        scan_over = 1'b1;
                    else if (b == 8'd0)
                    begin
                        zero_len_hit = 1'b1;
                        scan_over = 1'b1;
                    end
                    else
                    begin
                        dlen    = b;
                        dofs    = OFS_TYPE;
                        dtype   = '0;
                        cand    = '0;
                        ep_addr = '0;
                        if (b == 8'd1)
                        begin
                            judge_descriptor();
                            dlen = '0;
                        end
                    end
                end
                else
                begin
                    if (dofs == OFS_TYPE)
                        dtype = b;
                    else if (dtype == TYPE_ENDPOINT)
                    begin
                        if (dofs == OFS_EP_ADDR)
                            ep_addr = b;
                        else if (dofs == OFS_EP_ATTR)
                            cand[1] = b;
                    end
                    else
                    begin
                        if (dofs == OFS_IFACE_NUM)
                            cand[0] = b;
                        else if (dofs == OFS_CLASS)
                            cand[1] = b;
                        else if (dofs == OFS_SUBCLASS)
                            cand[2] = b;
                        else if (dofs == OFS_PROTOCOL)
                            cand[3] = b;
                    end
                    if ({1'b0, dofs} + 9'd1 >= {1'b0, dlen})
                    begin
                        judge_descriptor();
                        dlen = '0;
                        dofs = '0;
                    end
                    else
                        dofs = dofs + 8'd1;
                end
            end
        end
        if (scan_pos != POS_MAX)
            scan_pos = scan_pos + 16'd1;

        if (last)
        begin
            if (zero_len_hit)
                r.status = STATUS_ZERO_LEN;
            else if (!iface_hit)
                r.status = STATUS_NO_IFACE;
            else if (in_num == 4'd0 || out_num == 4'd0)
                r.status = STATUS_NO_EP;
            else
                r.status = STATUS_OK;
            r.interface_number = iface_num;
            r.in_endpoint      = in_num;
            r.out_endpoint     = out_num;
            r.config_id        = cfg_val;
            expected_reports.push_back(r);
            clear_scan_state();
        end
    endtask

    // Moves the assembled stream into the item queue, marking its final byte.
    task automatic flush_stream();
        scan_item_t it;
        for (int i = 0; i < stream_buf.size(); i++)
        begin
            it.value = stream_buf[i];
            it.last  = (i == stream_buf.size() - 1);
            scan_items_q.push_back(it);
        end
        phase_items += stream_buf.size();
        streams_sent++;
    endtask

    task automatic build_random_stream();
        logic [7:0]  d[$];
        logic [31:0] sz;
        logic [15:0] tlen;
        logic [7:0]  cls;
        logic [7:0]  sub;
        logic [7:0]  proto;
        logic [7:0]  addr;
        logic [7:0]  attr;
        int          hdr;
        int          ndesc;
        int          sel;
        int          cut;
        int          len;
        stream_buf.delete();
        if ($urandom_range(99) < 8)
        begin
            // Pure noise.
            repeat ($urandom_range(1, 24)) stream_buf.push_back(rand_byte());
        end
        else
        begin
            if ($urandom_range(9) == 0)
                hdr = $urandom_range(12);
            else
                hdr = 9;
            for (int i = 0; i < hdr; i++)
            begin
                if (i == 0)
                    stream_buf.push_back(hdr[7:0]);
                else if (i == 1)
                    stream_buf.push_back(TYPE_CONFIG);
                else
                    stream_buf.push_back(rand_byte());
            end

            ndesc = $urandom_range(1, 6);
            for (int k = 0; k < ndesc; k++)
            begin
                cls = ($urandom_range(4) != 0) ? match_class : rand_byte();
                case ($urandom_range(5))
                    0: sub = SUBCLASS_SCSI;
                    1: sub = SUBCLASS_RBC;
                    2: sub = SUBCLASS_ATAPI;
                    3: sub = SUBCLASS_UFI;
                    4: sub = SUBCLASS_SFF;
                    default: sub = rand_byte();
                endcase
                case ($urandom_range(5))
                    0: proto = PROTO_BOT;
                    1: proto = PROTO_CBI_INT;
                    2: proto = PROTO_CBI;
                    3: proto = PROTO_OBSOLETE;
                    4: proto = PROTO_UAS;
                    default: proto = rand_byte();
                endcase
                addr = rand_byte();
                if ($urandom_range(5) != 0)
                    addr[6:4] = 3'b000;
                attr = ($urandom_range(4) != 0) ? ATTR_BULK : rand_byte();

                if (k == 0 && $urandom_range(3) != 0)
                    sel = 0;
                else
                    sel = $urandom_range(99);

                d.delete();
                if (sel < 45)
                    d = '{8'd9, TYPE_INTERFACE, rand_byte(), rand_byte(), rand_byte(),
                          cls, sub, proto, rand_byte()};
                else if (sel < 85)
                    d = '{8'd7, TYPE_ENDPOINT, addr, attr, rand_byte(), rand_byte(),
                          rand_byte()};
                else if (sel < 95)
                begin
                    len = $urandom_range(2, 12);
                    d.push_back(len[7:0]);
                    repeat (len - 1) d.push_back(rand_byte());
                end
                else
                    d.push_back(8'h00);

                // Now and then the length byte is set to 1..8, dropping bytes past it.
                if (sel < 85 && $urandom_range(15) == 0)
                begin
                    cut = $urandom_range(1, 8);
                    while (d.size() > cut)
                        d.delete(d.size() - 1);
                    d[0] = cut[7:0];
                end
                foreach (d[j])
                    stream_buf.push_back(d[j]);
            end

            sz   = stream_buf.size();
            tlen = sz[15:0];
            case ($urandom_range(9))
                0: tlen = {8'h00, rand_byte()};
                1: tlen = {rand_byte(), rand_byte()};
                default: ;
            endcase
            if (hdr >= 4)
            begin
                stream_buf[2] = tlen[7:0];
                stream_buf[3] = tlen[15:8];
            end

            if ($urandom_range(6) == 0)
                repeat ($urandom_range(1, 6)) stream_buf.push_back(rand_byte());
            if (stream_buf.size() > 1 && $urandom_range(11) == 0)
            begin
                cut = $urandom_range(1, stream_buf.size() - 1);
                while (stream_buf.size() > cut)
                    stream_buf.delete(stream_buf.size() - 1);
            end
            if (stream_buf.size() == 0)
                stream_buf.push_back(rand_byte());
        end
        flush_stream();
    endtask

    task automatic set_device_class(input logic [7:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        match_class = v;
    endtask

    task automatic wait_drained();
        while (scan_items_q.size() != 0 || in_valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Input driver: a new item is offered only when the channel is free.
    always @(negedge clk)
    begin
        scan_item_t nxt;
        logic       send;
        if (rst_n && (!in_valid || byte_taken))
        begin
            send = scan_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (send)
            begin
                nxt = scan_items_q.pop_front();
                desc_byte <= nxt.value;
                last_byte <= nxt.last;
            end
            in_valid <= send;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: predicts on every accepted byte and checks every accepted report.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        byte_taken = rst_n && in_valid && !in_stall;
        if (byte_taken)
        begin
            predict_scan(desc_byte, last_byte);
            bytes_seen++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.status           = status_t'(status);
            got.interface_number = interface_number;
            got.in_endpoint      = in_endpoint;
            got.out_endpoint     = out_endpoint;
            got.config_id        = config_id;
            reports_checked++;
            if (expected_reports.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("ERROR: unexpected report status=%0d iface=%0d in=%0d out=%0d cfg=%0d",
                             got.status, got.interface_number, got.in_endpoint,
                             got.out_endpoint, got.config_id);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.status !== want.status ||
                    got.interface_number !== want.interface_number ||
                    got.in_endpoint !== want.in_endpoint ||
                    got.out_endpoint !== want.out_endpoint ||
                    got.config_id !== want.config_id)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display({"ERROR: report %0d expected status=%0d iface=%0d in=%0d ",
                                  "out=%0d cfg=%0d, got status=%0d iface=%0d in=%0d out=%0d cfg=%0d"},
                                 reports_checked, want.status, want.interface_number,
                                 want.in_endpoint, want.out_endpoint, want.config_id,
                                 got.status, got.interface_number, got.in_endpoint,
                                 got.out_endpoint, got.config_id);
                end
            end
        end
    end

    initial
    begin
        clear_scan_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed streams under the reset class: a lone zero byte, a lone 0xFF byte,
        // a zero-length descriptor found while header bytes are still being captured,
        // and a short but complete match that ends early on its second endpoint.
        stream_buf = '{8'h00};
        flush_stream();
        stream_buf = '{8'hFF};
        flush_stream();
        stream_buf = '{8'h03, 8'h00, 8'hFF, 8'h00};
        flush_stream();
        stream_buf = '{8'h06, TYPE_CONFIG, 8'd22, 8'h00, 8'h01, 8'hA5,
                       8'h08, TYPE_INTERFACE, 8'hFF, 8'h00, 8'h02, CLASS_RESET,
                       SUBCLASS_SCSI, PROTO_BOT,
                       8'h04, TYPE_ENDPOINT, 8'h81, ATTR_BULK,
                       8'h04, TYPE_ENDPOINT, 8'h0F, ATTR_BULK};
        flush_stream();
        wait_drained();

        for (int ph = 1; ph <= 8; ph++)
        begin
            case (ph % 4)
                1: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                2: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                3: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            case (ph)
                1, 5, 8: set_device_class(CLASS_RESET);
                2: set_device_class(8'hFF);
                3: set_device_class(8'h00);
                7: set_device_class(8'h01);
                default: set_device_class(rand_byte());
            endcase

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                build_random_stream();
            wait_drained();
        end

        $display("Scanned %0d descriptor bytes in %0d streams and checked %0d status reports,",
                 bytes_seen, streams_sent, reports_checked);
        $display("over eight class settings with and without input gaps and output stalls.");
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
